// ===== src/rilf_pkg.sv =====
// Package with the constants, codes and types of the RESP item length framer.
package rilf_pkg;
	localparam int MAX_DEPTH = 8;
	localparam int LEN_BITS = 32;
	localparam int DEPTH_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int NEST_W = $clog2(MAX_DEPTH + 1);
	localparam logic [LEN_BITS-1:0] LEN_LIMIT = {LEN_BITS{1'b1}};

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR = 8'h2a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_SIMPLE = 4'd1;
	localparam logic [3:0] PH_SIMPLE_CR = 4'd2;
	localparam logic [3:0] PH_BULK_NUM = 4'd3;
	localparam logic [3:0] PH_ARR_NUM = 4'd4;
	localparam logic [3:0] PH_BULK_LF = 4'd5;
	localparam logic [3:0] PH_ARR_LF = 4'd6;
	localparam logic [3:0] PH_BODY = 4'd7;
	localparam logic [3:0] PH_DISCARD = 4'd8;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_MALFORMED = 3'd1;
	localparam logic [2:0] ST_TRUNCATED = 3'd2;
	localparam logic [2:0] ST_OVERFLOW = 3'd3;
	localparam logic [2:0] ST_NONE = 3'd4;

	typedef struct packed {
		logic [LEN_BITS-1:0] left;
		logic has_anc;
		logic [DEPTH_W-1:0] anc;
	} level_t;
endpackage

// ===== src/resp_item_length_framer_top.sv =====
// Top level of the RESP item length framer: byte parser with an array level stack in memory.
//
//  channel   direction  handshake            payload
//  request   in         req_valid/req_stall  data_byte, buffer_end
//  response  out        rsp_valid/rsp_stall  item_length, status
//
// One request byte is taken every cycle unless requests stall; a response appears in the
// cycle after the byte that causes it, held in an output register. The open array levels
// sit in a one-port-write, one-port-read memory; the top level is kept in registers and a
// completed chain of levels reloads its survivor from memory through a read register.
// Reset is asynchronous and needs no clearing pass. Requests stall only while a response is
// held and the response side stalls.
module resp_item_length_framer_top import rilf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  logic [7:0] data_byte,
	input  logic buffer_end,
	output logic rsp_valid,
	input  logic rsp_stall,
	output logic [31:0] item_length,
	output logic [1:0] status
);
	logic [3:0] phase_q, nxt_phase;
	logic [LEN_BITS-1:0] accum_q, nxt_accum;
	logic neg_q, nxt_neg;
	logic first_q, nxt_first;
	logic digits_q, nxt_digits;
	logic [LEN_BITS-1:0] count_q, nxt_count;
	logic [LEN_BITS:0] left_q, nxt_left;
	logic [NEST_W-1:0] nest_q, nxt_nest;
	level_t top_q, nxt_top;
	logic load_q;
	level_t rd_s1;
	level_t mem [MAX_DEPTH];

	logic rsp_valid_q;
	logic [31:0] len_q;
	logic [1:0] status_q;

	logic acc, elem, done, mem_we, rd_req, emit;
	logic [DEPTH_W-1:0] mem_wa, rd_addr;
	level_t mem_wd;
	logic [2:0] st;
	logic [1:0] emit_st;
	logic [31:0] emit_len;
	logic [LEN_BITS+3:0] prod;
	logic [LEN_BITS-1:0] cnt_inc;
	logic [DEPTH_W-1:0] top_idx;

	assign req_stall = rsp_valid_q & rsp_stall;
	assign acc = req_valid & ~req_stall;
	assign rsp_valid = rsp_valid_q;
	assign item_length = len_q;
	assign status = status_q;
	assign cnt_inc = count_q + 1'b1;
	assign top_idx = DEPTH_W'(nest_q - 1'b1);
	assign prod = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1)
		+ (LEN_BITS+4)'(data_byte - CH_ZERO);

	always_comb begin
		nxt_phase = phase_q;
		nxt_accum = accum_q;
		nxt_neg = neg_q;
		nxt_first = first_q;
		nxt_digits = digits_q;
		nxt_count = count_q;
		nxt_left = left_q;
		nxt_nest = nest_q;
		nxt_top = top_q;
		mem_we = 1'b0;
		mem_wa = top_idx;
		mem_wd = top_q;
		rd_req = 1'b0;
		rd_addr = top_q.anc;
		st = ST_NONE;
		elem = 1'b0;
		done = 1'b0;
		emit = 1'b0;
		emit_st = 2'd0;
		emit_len = 32'd0;
		if (load_q) begin
			nxt_top.left = rd_s1.left - 1'b1;
			nxt_top.has_anc = rd_s1.has_anc;
			nxt_top.anc = rd_s1.anc;
		end
		if (acc && phase_q == PH_DISCARD) begin
			if (buffer_end) begin
				nxt_phase = PH_IDLE;
				nxt_accum = '0;
				nxt_neg = 1'b0;
				nxt_first = 1'b1;
				nxt_digits = 1'b0;
				nxt_count = '0;
				nxt_left = '0;
				nxt_nest = '0;
			end
		end else if (acc) begin
			if (count_q == LEN_LIMIT) begin
				st = ST_OVERFLOW;
			end else begin
				nxt_count = cnt_inc;
				case (phase_q)
					PH_IDLE: begin
						if (data_byte == CH_PLUS || data_byte == CH_MINUS ||
							data_byte == CH_COLON) begin
							nxt_phase = PH_SIMPLE;
						end else if (data_byte == CH_DOLLAR || data_byte == CH_STAR) begin
							nxt_phase = (data_byte == CH_DOLLAR) ? PH_BULK_NUM : PH_ARR_NUM;
							nxt_accum = '0;
							nxt_neg = 1'b0;
							nxt_first = 1'b1;
							nxt_digits = 1'b0;
						end else begin
							st = ST_MALFORMED;
						end
					end
					PH_SIMPLE: begin
						if (data_byte == CH_CR) nxt_phase = PH_SIMPLE_CR;
					end
					PH_SIMPLE_CR: begin
						if (data_byte == CH_LF) elem = 1'b1;
						else if (data_byte != CH_CR) nxt_phase = PH_SIMPLE;
					end
					PH_BULK_NUM, PH_ARR_NUM: begin
						if (first_q && (data_byte == CH_PLUS || data_byte == CH_MINUS)) begin
							nxt_first = 1'b0;
							nxt_neg = (data_byte == CH_MINUS);
						end else if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
							nxt_first = 1'b0;
							if (prod > (LEN_BITS+4)'(LEN_LIMIT)) begin
								st = ST_OVERFLOW;
							end else begin
								nxt_accum = prod[LEN_BITS-1:0];
								nxt_digits = 1'b1;
							end
						end else if (data_byte == CH_CR && digits_q) begin
							nxt_phase = (phase_q == PH_BULK_NUM) ? PH_BULK_LF : PH_ARR_LF;
						end else begin
							st = ST_MALFORMED;
						end
					end
					PH_BULK_LF: begin
						if (data_byte != CH_LF) begin
							st = ST_MALFORMED;
						end else if (neg_q && accum_q == LEN_BITS'(1)) begin
							elem = 1'b1;
						end else if (neg_q && accum_q != '0) begin
							st = ST_MALFORMED;
						end else begin
							nxt_left = {1'b0, accum_q} + (LEN_BITS+1)'(2);
							nxt_phase = PH_BODY;
						end
					end
					PH_ARR_LF: begin
						if (data_byte != CH_LF) begin
							st = ST_MALFORMED;
						end else if (accum_q == '0 || (neg_q && accum_q == LEN_BITS'(1))) begin
							elem = 1'b1;
						end else if (neg_q) begin
							st = ST_MALFORMED;
						end else if (nest_q >= NEST_W'(MAX_DEPTH)) begin
							st = ST_OVERFLOW;
						end else begin
							if (nest_q != '0) begin
								mem_we = 1'b1;
								nxt_top.has_anc = (top_q.left > LEN_BITS'(1)) | top_q.has_anc;
								nxt_top.anc = (top_q.left > LEN_BITS'(1)) ? top_idx : top_q.anc;
							end else begin
								nxt_top.has_anc = 1'b0;
								nxt_top.anc = '0;
							end
							nxt_top.left = accum_q;
							nxt_nest = nest_q + 1'b1;
							nxt_phase = PH_IDLE;
						end
					end
					PH_BODY: begin
						if (left_q == (LEN_BITS+1)'(2) && data_byte != CH_CR) begin
							st = ST_MALFORMED;
						end else if (left_q == (LEN_BITS+1)'(1) && data_byte != CH_LF) begin
							st = ST_MALFORMED;
						end else begin
							if (left_q != '0) nxt_left = left_q - 1'b1;
							if (left_q <= (LEN_BITS+1)'(1)) elem = 1'b1;
						end
					end
					default: begin
						st = ST_MALFORMED;
					end
				endcase
			end
			if (elem) begin
				nxt_phase = PH_IDLE;
				if (nest_q == '0) begin
					done = 1'b1;
				end else if (top_q.left > LEN_BITS'(1)) begin
					nxt_top.left = top_q.left - 1'b1;
				end else if (!top_q.has_anc) begin
					done = 1'b1;
					nxt_nest = '0;
				end else begin
					nxt_nest = NEST_W'(top_q.anc) + 1'b1;
					rd_req = 1'b1;
				end
			end
			if (done) st = ST_OK;
			if (st != ST_NONE || buffer_end) begin
				emit = 1'b1;
				emit_st = (st != ST_NONE) ? st[1:0] : ST_TRUNCATED[1:0];
				emit_len = done ? cnt_inc[31:0] : 32'd0;
				nxt_phase = (st != ST_NONE && st != ST_OK && !buffer_end) ? PH_DISCARD
					: PH_IDLE;
				nxt_accum = '0;
				nxt_neg = 1'b0;
				nxt_first = 1'b1;
				nxt_digits = 1'b0;
				nxt_count = '0;
				nxt_left = '0;
				nxt_nest = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (rd_req) rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			accum_q <= '0;
			neg_q <= 1'b0;
			first_q <= 1'b1;
			digits_q <= 1'b0;
			count_q <= '0;
			left_q <= '0;
			nest_q <= '0;
			top_q <= '0;
			load_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			phase_q <= nxt_phase;
			accum_q <= nxt_accum;
			neg_q <= nxt_neg;
			first_q <= nxt_first;
			digits_q <= nxt_digits;
			count_q <= nxt_count;
			left_q <= nxt_left;
			nest_q <= nxt_nest;
			top_q <= nxt_top;
			load_q <= rd_req;
			if (emit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			len_q <= emit_len;
			status_q <= emit_st;
		end
	end

	a_nest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nest_q <= NEST_W'(MAX_DEPTH)) else $error("nest level beyond stack depth");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_q |-> (phase_q == PH_IDLE)) else $error("stack reload outside type byte phase");
	a_anc_below: assert property (@(posedge clk) disable iff (!arst_n)
		(nest_q != '0 && top_q.has_anc && !load_q) |-> (NEST_W'(top_q.anc) + 1'b1 < nest_q))
		else $error("ancestor index not below top level");
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(acc)) else $error("response without request");
endmodule
